FILE: design/bsab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsab_pkg;

  // Input word kinds
  localparam logic [1:0] KIND_SERIAL = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // ASCII codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] SYNC_VALUE = 8'h80;

  // Longest result sequence per input word
  localparam int unsigned MaxWords = 6;
  localparam int unsigned CntW     = $clog2(MaxWords + 1);

  // Decimal digits of one byte
  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Parser outcome for one received serial byte
  typedef struct packed {
    logic       nmi;
    logic       rst;
    logic       unk;
    logic       num_done;
    logic [7:0] num_value;
  } parse_t;

endpackage
`default_nettype wire

FILE: design/bsab_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one word per serial byte or bus access
interface bsab_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_in;

  modport source (output valid, output kind, output byte_in, input ready);
  modport sink   (input valid, input kind, input byte_in, output ready);
endinterface

// Output channel: one word per result
interface bsab_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       read_valid;
  logic [7:0] read_data;
  logic       nmi_pulse;
  logic       reset_pulse;
  logic       unknown_command;
  logic       last;

  modport source (output valid, output tx_valid, output tx_byte, output read_valid,
                  output read_data, output nmi_pulse, output reset_pulse,
                  output unknown_command, output last, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input read_valid,
                  input read_data, input nmi_pulse, input reset_pulse,
                  input unknown_command, input last, output ready);
endinterface
`default_nettype wire

FILE: design/bsab_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Serial command parser: '$' prefix, command letter, decimal number
module bsab_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              strobe_i,
  input  wire logic [7:0]        byte_i,
  output bsab_pkg::parse_t       parse_o
);

  logic       awaiting_q, awaiting_d;
  logic       reading_q, reading_d;
  logic [7:0] acc_q, acc_d;
  logic       is_digit;
  logic [7:0] digit_val;

  assign is_digit  = (byte_i >= bsab_pkg::CH_0) && (byte_i <= bsab_pkg::CH_9);
  assign digit_val = byte_i - bsab_pkg::CH_0;

  // Next state and outcome of the byte
  always_comb begin
    awaiting_d = awaiting_q;
    reading_d  = reading_q;
    acc_d      = acc_q;
    parse_o    = '0;
    parse_o.num_value = acc_q;
    if (reading_q) begin
      if (is_digit) begin
        // acc * 10 + digit, modulo 256
        acc_d = (acc_q << 3) + (acc_q << 1) + digit_val;
      end else begin
        parse_o.num_done = 1'b1;
        reading_d        = 1'b0;
      end
    end else if (!awaiting_q && (byte_i == bsab_pkg::CH_DOLLAR)) begin
      awaiting_d = 1'b1;
    end else begin
      if (byte_i == bsab_pkg::CH_N) begin
        parse_o.nmi = 1'b1;
      end else if (byte_i == bsab_pkg::CH_R) begin
        parse_o.rst = 1'b1;
      end else if (byte_i == bsab_pkg::CH_D) begin
        acc_d     = '0;
        reading_d = 1'b1;
      end else begin
        parse_o.unk = 1'b1;
      end
      awaiting_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      reading_q  <= 1'b0;
      acc_q      <= '0;
    end else if (strobe_i) begin
      awaiting_q <= awaiting_d;
      reading_q  <= reading_d;
      acc_q      <= acc_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/bsab_digits.sv
`timescale 1ns / 1ps
`default_nettype none
// Binary to decimal by repeated subtraction of 100, then 10, on one subtractor
module bsab_digits (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [7:0]    value_i,
  output logic               done_o,
  output bsab_pkg::digits_t  digits_o
);

  logic       busy_q, busy_d;
  logic       tens_q, tens_d;   // 0: hundreds pass, 1: tens pass
  logic [7:0] rem_q, rem_d;
  logic [1:0] hund_q, hund_d;
  logic [3:0] cnt10_q, cnt10_d;
  logic [7:0] step;
  logic [8:0] diff;

  assign step = tens_q ? 8'd10 : 8'd100;
  assign diff = {1'b0, rem_q} - {1'b0, step};

  // One subtract-and-compare per cycle
  always_comb begin
    busy_d  = busy_q;
    tens_d  = tens_q;
    rem_d   = rem_q;
    hund_d  = hund_q;
    cnt10_d = cnt10_q;
    done_o  = 1'b0;
    if (start_i) begin
      busy_d  = 1'b1;
      tens_d  = 1'b0;
      rem_d   = value_i;
      hund_d  = '0;
      cnt10_d = '0;
    end else if (busy_q) begin
      if (!diff[8]) begin
        rem_d = diff[7:0];
        if (tens_q) cnt10_d = cnt10_q + 4'd1;
        else        hund_d  = hund_q + 2'd1;
      end else if (!tens_q) begin
        tens_d = 1'b1;
      end else begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign digits_o.hund = hund_q;
  assign digits_o.tens = cnt10_q;
  assign digits_o.ones = rem_q[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tens_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      tens_q <= tens_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    hund_q  <= hund_d;
    cnt10_q <= cnt10_d;
  end

endmodule
`default_nettype wire

FILE: design/bus_to_serial_ascii_bridge_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Payload                                        | Handshake
// in_i     | in  | kind, byte_in                                  | valid/ready
// out_o    | out | tx_valid, tx_byte, read_valid, read_data,      | valid/ready
//          |     | nmi_pulse, reset_pulse, unknown_command, last  |
//
// Serial byte: one word to the output register; bus read: one or three words.
// Bus write: the digit subtractor first (one compare per cycle,
// hundreds then tens), then 4 to 6 words, each sent as the output takes it.
// Input ready only while idle; words go out through a registered output stage.
// Reset clears the parser, held byte (to the sync value) and pending mark.
module bus_to_serial_ascii_bridge_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bsab_in_if.sink   in_i,
  bsab_out_if.source out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIG  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam int unsigned CntW = bsab_pkg::CntW;

  logic [1:0]      state_q, state_d;
  logic            in_acc;
  logic            slot_free;
  logic            emit_last;

  logic [7:0]      held_q, held_d;
  logic            pend_q, pend_d;

  // Word sequence being emitted
  logic [7:0]      seq_q [bsab_pkg::MaxWords];
  logic [7:0]      seq_d [bsab_pkg::MaxWords];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            txv_q, txv_d;
  logic            rdv_q, rdv_d;
  logic [7:0]      rdd_q, rdd_d;
  logic            nmi_q, nmi_d;
  logic            rstp_q, rstp_d;
  logic            unk_q, unk_d;

  // Output register
  logic            ovld_q, ovld_d;
  logic            o_txv_q, o_rdv_q, o_nmi_q, o_rst_q, o_unk_q, o_last_q;
  logic [7:0]      o_txb_q, o_rdd_q;

  bsab_pkg::parse_t  parse;
  bsab_pkg::digits_t digits;
  logic              dig_done;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !ovld_q || out_o.ready;
  assign emit_last  = (idx_q == cnt_q - CntW'(1));

  bsab_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .strobe_i (in_acc && (in_i.kind == bsab_pkg::KIND_SERIAL)),
    .byte_i   (in_i.byte_in),
    .parse_o  (parse)
  );

  bsab_digits u_digits (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && (in_i.kind == bsab_pkg::KIND_WRITE)),
    .value_i  (in_i.byte_in),
    .done_o   (dig_done),
    .digits_o (digits)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    pend_d  = pend_q;
    seq_d   = seq_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    txv_d   = txv_q;
    rdv_d   = rdv_q;
    rdd_d   = rdd_q;
    nmi_d   = nmi_q;
    rstp_d  = rstp_q;
    unk_d   = unk_q;
    ovld_d  = ovld_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d  = '0;
          nmi_d  = 1'b0;
          rstp_d = 1'b0;
          unk_d  = 1'b0;
          rdv_d  = 1'b0;
          txv_d  = 1'b0;
          cnt_d  = CntW'(1);
          case (in_i.kind)
            bsab_pkg::KIND_SERIAL: begin
              nmi_d   = parse.nmi;
              rstp_d  = parse.rst;
              unk_d   = parse.unk;
              if (parse.num_done) begin
                held_d = parse.num_value;
                pend_d = 1'b1;
              end
              state_d = S_EMIT;
            end
            bsab_pkg::KIND_WRITE: begin
              held_d  = '0;
              pend_d  = 1'b0;
              state_d = S_DIG;
            end
            bsab_pkg::KIND_READ: begin
              rdv_d = 1'b1;
              rdd_d = held_q;
              if (pend_q) begin
                txv_d    = 1'b1;
                seq_d[0] = bsab_pkg::CH_DOLLAR;
                seq_d[1] = bsab_pkg::CH_J;
                seq_d[2] = bsab_pkg::CH_NUL;
                cnt_d    = CntW'(3);
                pend_d   = 1'b0;
              end
              state_d = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DIG: begin
        if (dig_done) begin
          txv_d    = 1'b1;
          seq_d[0] = bsab_pkg::CH_DOLLAR;
          seq_d[1] = bsab_pkg::CH_I;
          if (digits.hund != '0) begin
            seq_d[2] = bsab_pkg::CH_0 + {6'd0, digits.hund};
            seq_d[3] = bsab_pkg::CH_0 + {4'd0, digits.tens};
            seq_d[4] = bsab_pkg::CH_0 + {4'd0, digits.ones};
            seq_d[5] = bsab_pkg::CH_NUL;
            cnt_d    = CntW'(6);
          end else if (digits.tens != '0) begin
            seq_d[2] = bsab_pkg::CH_0 + {4'd0, digits.tens};
            seq_d[3] = bsab_pkg::CH_0 + {4'd0, digits.ones};
            seq_d[4] = bsab_pkg::CH_NUL;
            cnt_d    = CntW'(5);
          end else begin
            seq_d[2] = bsab_pkg::CH_0 + {4'd0, digits.ones};
            seq_d[3] = bsab_pkg::CH_NUL;
            cnt_d    = CntW'(4);
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ovld_d = 1'b1;
          if (emit_last) state_d = S_IDLE;
          else           idx_d   = idx_q + CntW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= bsab_pkg::SYNC_VALUE;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
      cnt_q   <= CntW'(1);
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    txv_q  <= txv_d;
    rdv_q  <= rdv_d;
    rdd_q  <= rdd_d;
    nmi_q  <= nmi_d;
    rstp_q <= rstp_d;
    unk_q  <= unk_d;
  end

  // Output word load
  always_ff @(posedge clk_i) begin
    if ((state_q == S_EMIT) && slot_free) begin
      o_txv_q  <= txv_q;
      o_txb_q  <= txv_q ? seq_q[idx_q[$clog2(bsab_pkg::MaxWords)-1:0]] : 8'd0;
      o_rdv_q  <= rdv_q && emit_last;
      o_rdd_q  <= (rdv_q && emit_last) ? rdd_q : 8'd0;
      o_nmi_q  <= nmi_q;
      o_rst_q  <= rstp_q;
      o_unk_q  <= unk_q;
      o_last_q <= emit_last;
    end
  end

  assign out_o.valid           = ovld_q;
  assign out_o.tx_valid        = o_txv_q;
  assign out_o.tx_byte         = o_txb_q;
  assign out_o.read_valid      = o_rdv_q;
  assign out_o.read_data       = o_rdd_q;
  assign out_o.nmi_pulse       = o_nmi_q;
  assign out_o.reset_pulse     = o_rst_q;
  assign out_o.unknown_command = o_unk_q;
  assign out_o.last            = o_last_q;

  // Digit unit finishes only while the sequencer waits for it
  a_dig_done_in_dig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_done |-> (state_q == S_DIG))
    else $error("digit unit done outside wait state");

  // Emit index never passes the word count
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (idx_q < cnt_q) && (cnt_q != '0)
      && (cnt_q <= CntW'(bsab_pkg::MaxWords)))
    else $error("emit index out of range");

  // A bus write clears the held byte and pending mark while its digits are computed
  a_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIG) |-> !pend_q && (held_q == 8'd0))
    else $error("bus write did not clear held byte");

  // Pulses never share a word with serial transmit or read data, and end their sequence
  a_word_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && (o_nmi_q || o_rst_q || o_unk_q) |-> !o_txv_q && !o_rdv_q && o_last_q)
    else $error("mixed result word");

endmodule
`default_nettype wire
